// ===== rtl/frame_crc16_with_extra_byte_defines.svh =====
// Assertion macros for the frame checksum block.
`ifndef FRAME_CRC16_WITH_EXTRA_BYTE_DEFINES_SVH
`define FRAME_CRC16_WITH_EXTRA_BYTE_DEFINES_SVH

`ifndef SYNTHESIS

`define FCRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCRC_ASSERT_SAME(lbl, ante, cons, msg)
`define FCRC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/fcrc_pkg.sv =====
package fcrc_pkg;

  localparam logic [15:0] CRC_RESET_VALUE = 16'hFFFF;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

  localparam logic [7:0] MID_29  = 8'd29;
  localparam logic [7:0] MID_66  = 8'd66;
  localparam logic [7:0] MID_128 = 8'd128;
  localparam logic [7:0] MID_134 = 8'd134;
  localparam logic [7:0] MID_152 = 8'd152;
  localparam logic [7:0] MID_158 = 8'd158;
  localparam logic [7:0] MID_201 = 8'd201;
  localparam logic [7:0] MID_202 = 8'd202;
  localparam logic [7:0] MID_203 = 8'd203;
  localparam logic [7:0] MID_224 = 8'd224;
  localparam logic [7:0] MID_230 = 8'd230;
  localparam logic [7:0] MID_246 = 8'd246;
  localparam logic [7:0] MID_248 = 8'd248;
  localparam logic [7:0] MID_254 = 8'd254;
  localparam logic [7:0] LEN_202_SHORT = 8'd42;
  localparam logic [7:0] EXTRA_UNKNOWN = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic [7:0] extra;
  } entry_t;

  function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
  endfunction

  function automatic logic [7:0] extra_for(input logic [7:0] id, input logic [7:0] len);
    logic [7:0] e;
    unique case (id)
      MID_29:  e = 8'd115;
      MID_66:  e = 8'd148;
      MID_128: e = 8'd226;
      MID_134: e = 8'd229;
      MID_152: e = 8'd208;
      MID_158: e = 8'd134;
      MID_201: e = 8'd126;
      MID_202: e = (len == LEN_202_SHORT) ? 8'd7 : 8'd11;
      MID_203: e = 8'd85;
      MID_224: e = 8'd102;
      MID_230: e = 8'd163;
      MID_246: e = 8'd184;
      MID_248: e = 8'd8;
      MID_254: e = 8'd46;
      default: e = EXTRA_UNKNOWN;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/fcrc_fifo.sv =====
module fcrc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fcrc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output fcrc_pkg::entry_t pop_data
);
  import fcrc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t          mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == DepthCnt);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/fcrc_front.sv =====
module fcrc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_first_byte,
  input  logic             in_last_byte,
  input  logic [7:0]       in_message_id,
  input  logic [7:0]       in_payload_length,
  input  logic             q_full,
  output logic             q_push,
  output fcrc_pkg::entry_t q_data
);
  import fcrc_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.data_byte = in_data_byte;
    q_data.first     = in_first_byte;
    q_data.last      = in_last_byte;
    q_data.extra     = extra_for(in_message_id, in_payload_length);
  end

endmodule

// ===== rtl/fcrc_back.sv =====
`include "frame_crc16_with_extra_byte_defines.svh"

module fcrc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             q_not_empty,
  input  fcrc_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_checksum,
  output logic             out_frame_done
);
  import fcrc_pkg::*;

  logic [15:0] init_r;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        frame_done_r;
  logic [15:0] crc_base, crc_byte;

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    crc_base = q_data.first ? init_r : crc_r;
    crc_byte = fold_byte(crc_base, q_data.data_byte);
    crc_nxt  = q_data.last ? fold_byte(crc_byte, q_data.extra) : crc_byte;
    out_valid_nxt = q_pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= CRC_RESET_VALUE;
      crc_r       <= CRC_RESET_VALUE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
      end
      if (q_pop) begin
        crc_r <= crc_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_done_r <= q_data.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_checksum   = crc_r;
  assign out_frame_done = frame_done_r;

  `FCRC_ASSERT_NEXT(a_pop_shows_result, q_pop, out_valid_r, "popped transaction not presented")
  `FCRC_ASSERT_NEXT(a_done_tracks_last, q_pop, frame_done_r == $past(q_data.last), "frame_done mismatch")
  `FCRC_ASSERT_NEXT(a_crc_holds_idle, !q_pop, $stable(crc_r), "crc changed without a transaction")
  `FCRC_ASSERT_SAME(a_no_pop_over_stall, out_valid_r && out_stall, !q_pop, "result overwritten while stalled")

endmodule

// ===== rtl/frame_crc16_with_extra_byte.sv =====
// Frame checksum: reflected 16-bit MCRF4XX CRC over frame bytes, one byte per
// transaction, sustaining one byte per clock while out_stall is low. first_byte
// reloads the CRC from the cfg register (reset 0xFFFF) before folding; on last_byte
// the per-message extra byte is folded in too and frame_done is set. Every byte
// returns one result with the running CRC. Accepted bytes are classified (extra
// byte looked up) and queued in a FifoDepth-entry queue; the back end folds one
// queued byte per cycle, unless a stalled result is held, into the CRC register,
// which doubles as the output register. Write the register only while idle.
module frame_crc16_with_extra_byte #(
  parameter int unsigned FifoDepth = fcrc_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_message_id,
  input  logic [7:0]  in_payload_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic        out_frame_done
);
  import fcrc_pkg::*;

  entry_t push_data, pop_data;
  logic   q_push, q_full, q_pop, q_not_empty;

  fcrc_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .in_message_id     (in_message_id),
    .in_payload_length (in_payload_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (push_data)
  );

  fcrc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  fcrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_not_empty    (q_not_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_checksum   (out_checksum),
    .out_frame_done (out_frame_done)
  );

endmodule

// ===== tb/sv/tb_frame_crc16_with_extra_byte.sv =====
module tb_frame_crc16_with_extra_byte;
  timeunit 1ns;
  timeprecision 1ps;

  import fcrc_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] message_id;
    logic [7:0] payload_length;
  } frame_byte_t;

  typedef struct {
    logic [15:0] checksum;
    logic        frame_done;
  } crc_result_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic [7:0]  in_message_id = '0;
  logic [7:0]  in_payload_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_checksum;
  logic        out_frame_done;

  frame_byte_t byte_queue[$];
  crc_result_t expected_crcs[$];
  frame_byte_t on_bus;
  logic [15:0] init_value = CRC_RESET_VALUE;
  logic [15:0] running_crc = CRC_RESET_VALUE;
  logic [7:0]  known_ids [0:13];

  bit          sender_bursty = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned hold_req_n = 0;
  int unsigned hold_seen_n = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_n = 0;
  int unsigned fail_count = 0;

  frame_crc16_with_extra_byte u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .in_message_id    (in_message_id),
    .in_payload_length(in_payload_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checksum     (out_checksum),
    .out_frame_done   (out_frame_done)
  );

  always #5 clk = ~clk;

  // bitwise reflected CRC, polynomial 0x8408
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] extra_byte_for(input logic [7:0] id, input logic [7:0] len);
    case (id)
      MID_29:  return 8'd115;
      MID_66:  return 8'd148;
      MID_128: return 8'd226;
      MID_134: return 8'd229;
      MID_152: return 8'd208;
      MID_158: return 8'd134;
      MID_201: return 8'd126;
      MID_202: return (len == LEN_202_SHORT) ? 8'd7 : 8'd11;
      MID_203: return 8'd85;
      MID_224: return 8'd102;
      MID_230: return 8'd163;
      MID_246: return 8'd184;
      MID_248: return 8'd8;
      MID_254: return 8'd46;
      default: return EXTRA_UNKNOWN;
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] d, input logic f, input logic l,
                                     input logic [7:0] id, input logic [7:0] len);
    frame_byte_t b;
    b.data_byte = d;
    b.first_byte = f;
    b.last_byte = l;
    b.message_id = id;
    b.payload_length = len;
    byte_queue.push_back(b);
  endfunction

  task automatic queue_random_frames(input int unsigned n_bytes);
    int unsigned done_n;
    int unsigned len_n;
    int unsigned pick;
    logic [7:0]  id;
    logic [7:0]  len;
    done_n = 0;
    while (done_n < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: flags and content unconstrained
        queue_byte(8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        done_n++;
      end else begin
        len_n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int unsigned k = 0; k < len_n; k++) begin
          id = 8'($urandom);
          len = 8'($urandom);
          if (k == len_n - 1) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
              id = known_ids[$urandom_range(0, 13)];
            end else if (pick == 6) begin
              id = MID_202;
              len = LEN_202_SHORT;
            end
          end
          queue_byte(8'($urandom), k == 0, k == len_n - 1, id, len);
        end
        done_n += len_n;
      end
    end
  endtask

  task automatic wait_idle;
    while (byte_queue.size() != 0 || in_valid || expected_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_init(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    init_value = v;
  endtask

  // sender: predicts at acceptance, then presents the next byte
  always @(posedge clk) begin : driver
    logic [15:0] c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        c = on_bus.first_byte ? init_value : running_crc;
        c = crc_fold_byte(c, on_bus.data_byte);
        if (on_bus.last_byte) begin
          c = crc_fold_byte(c, extra_byte_for(on_bus.message_id, on_bus.payload_length));
        end
        running_crc = c;
        expected_crcs.push_back('{c, on_bus.last_byte});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          on_bus = byte_queue.pop_front();
          in_data_byte <= on_bus.data_byte;
          in_first_byte <= on_bus.first_byte;
          in_last_byte <= on_bus.last_byte;
          in_message_id <= on_bus.message_id;
          in_payload_length <= on_bus.payload_length;
          in_valid <= 1'b1;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0 && sender_bursty) begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction, then decides the next stall
  always @(posedge clk) begin : monitor
    crc_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_crcs.size() == 0) begin
          $error("unexpected result transaction: checksum %h frame_done %b",
                 out_checksum, out_frame_done);
          fail_count++;
        end else begin
          want = expected_crcs.pop_front();
          if (out_checksum !== want.checksum) begin
            $error("checksum: expected %h, actual %h", want.checksum, out_checksum);
            fail_count++;
          end
          if (out_frame_done !== want.frame_done) begin
            $error("frame_done: expected %b, actual %b", want.frame_done, out_frame_done);
            fail_count++;
          end
        end
      end
      cycle_n++;
      if (hold_seen_n != hold_req_n) begin
        hold_seen_n = hold_req_n;
        hold_left = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:    out_stall <= 1'b0;
          STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
          STALL_PATTERN: out_stall <= ((cycle_n % 5) < 2);
          default:       out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin : stimulus
    known_ids[0] = MID_29;   known_ids[1] = MID_66;   known_ids[2] = MID_128;
    known_ids[3] = MID_134;  known_ids[4] = MID_152;  known_ids[5] = MID_158;
    known_ids[6] = MID_201;  known_ids[7] = MID_202;  known_ids[8] = MID_203;
    known_ids[9] = MID_224;  known_ids[10] = MID_230; known_ids[11] = MID_246;
    known_ids[12] = MID_248; known_ids[13] = MID_254;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset init value; single-byte frames over the whole id table
    queue_byte(8'h00, 1'b1, 1'b1, 8'h00, 8'h00);
    queue_byte(8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
    for (int i = 0; i < 14; i++) begin
      queue_byte(8'h55 ^ 8'(i), 1'b1, 1'b1, known_ids[i], 8'h00);
    end
    queue_byte(8'hAA, 1'b1, 1'b1, MID_202, LEN_202_SHORT);
    // restart mid-frame, ignored id on inner bytes, bytes after a last byte
    queue_byte(8'h21, 1'b1, 1'b0, MID_202, LEN_202_SHORT);
    queue_byte(8'hA5, 1'b0, 1'b0, MID_29, 8'h10);
    queue_byte(8'h10, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_byte(8'h80, 1'b0, 1'b1, MID_254, LEN_202_SHORT);
    queue_byte(8'h7E, 1'b0, 1'b0, 8'h00, 8'h00);
    queue_byte(8'h01, 1'b0, 1'b0, 8'h00, 8'h00);
    wait_idle();

    // init change with a frame still open: running CRC must carry over
    write_init(16'h0000);
    sender_bursty = 1'b1;
    stall_mode = STALL_RANDOM;
    queue_byte(8'h33, 1'b0, 1'b0, 8'h00, 8'h00);
    queue_byte(8'hC3, 1'b0, 1'b1, MID_202, 8'd43);
    queue_random_frames(300);
    wait_idle();

    write_init(16'hFFFF);
    sender_bursty = 1'b0;
    stall_mode = STALL_NONE;
    queue_random_frames(300);
    hold_req_n <= hold_req_n + 1;
    wait_idle();

    write_init(16'h1D0F);
    sender_bursty = 1'b1;
    stall_mode = STALL_PATTERN;
    queue_random_frames(300);
    wait_idle();

    write_init(16'($urandom));
    stall_mode = STALL_HEAVY;
    queue_random_frames(300);
    wait_idle();

    write_init(16'h8000);
    sender_bursty = 1'b0;
    stall_mode = STALL_RANDOM;
    queue_random_frames(300);
    hold_req_n <= hold_req_n + 1;
    wait_idle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
